// File: design/tlws_pkg.sv
// ----------------------------------------------------------------------------
// tlws_pkg
// Shared widths, codes and item types of the ticket lock with wait slots.
// ----------------------------------------------------------------------------
package tlws_pkg;

  localparam int SLOTS       = 16;
  localparam int TICKET_BITS = 16;
  localparam int TID_BITS    = 10;
  localparam int SLOT_BITS   = $clog2(SLOTS);

  typedef enum logic {
    ACT_LOCK   = 1'b0,
    ACT_UNLOCK = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_GRANTED    = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_FULL       = 3'd2,
    ST_WOKE       = 3'd3,
    ST_NOWAIT     = 3'd4,
    ST_UNLOCK_ERR = 3'd5
  } status_t;

  typedef struct packed {
    action_t             action;
    logic [TID_BITS-1:0] thread_id;
  } in_t;

  typedef struct packed {
    status_t                status;
    logic [TICKET_BITS-1:0] ticket;
    logic                   wake_valid;
    logic [TID_BITS-1:0]    wake_thread;
  } out_t;

endpackage

// File: design/tlws_slot_ram.sv
// ----------------------------------------------------------------------------
// tlws_slot_ram
// Wait-slot thread id store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tlws_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/ticket_lock_wait_slots.sv
// ----------------------------------------------------------------------------
// ticket_lock_wait_slots
// Ticket lock with a table of wait slots indexed by ticket modulo slot count.
//
//   channel  ports                      handshake
//   input    start, busy, in_item       taken when start high and busy low
//   result   out_valid, out_item        one-cycle strobe, cannot be held off
//
// An item is decided in its accept cycle, which also writes the slot store;
// the next cycle shows the result with the waiter read from the store's
// registered port. busy is high during that result cycle, so no new item is
// taken while a result is shown. After reset the counters are zero and all
// slots are free; the block is ready at once.
// ----------------------------------------------------------------------------
module ticket_lock_wait_slots (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  tlws_pkg::in_t  in_item,
  output logic           out_valid,
  output tlws_pkg::out_t out_item
);

  logic [tlws_pkg::TICKET_BITS-1:0] next_r, next_nxt;
  logic [tlws_pkg::TICKET_BITS-1:0] on_call_r, on_call_nxt;
  logic [tlws_pkg::SLOTS-1:0]       occ_r, occ_nxt;
  logic                             valid_r, valid_nxt;
  tlws_pkg::status_t                status_r, status_nxt;
  logic [tlws_pkg::TICKET_BITS-1:0] ticket_r, ticket_nxt;
  logic                             wake_r, wake_nxt;

  logic                             accept;
  logic [tlws_pkg::TICKET_BITS-1:0] gap;
  logic [tlws_pkg::TICKET_BITS-1:0] on_call_inc;
  logic [tlws_pkg::TICKET_BITS-1:0] lk_mod;
  logic [tlws_pkg::TICKET_BITS-1:0] ul_mod;
  logic [tlws_pkg::SLOT_BITS-1:0]   lk_slot;
  logic [tlws_pkg::SLOT_BITS-1:0]   ul_slot;
  logic                             ram_we;
  logic [tlws_pkg::TID_BITS-1:0]    ram_rdata;

  assign accept      = start && !busy;
  assign busy        = valid_r;
  assign gap         = next_r - on_call_r;
  assign on_call_inc = on_call_r + tlws_pkg::TICKET_BITS'(1);
  assign lk_mod      = tlws_pkg::TICKET_BITS'(next_r % tlws_pkg::SLOTS);
  assign ul_mod      = tlws_pkg::TICKET_BITS'(on_call_inc % tlws_pkg::SLOTS);
  assign lk_slot     = lk_mod[tlws_pkg::SLOT_BITS-1:0];
  assign ul_slot     = ul_mod[tlws_pkg::SLOT_BITS-1:0];

  always_comb begin
    next_nxt    = next_r;
    on_call_nxt = on_call_r;
    occ_nxt     = occ_r;
    valid_nxt   = accept;
    status_nxt  = status_r;
    ticket_nxt  = ticket_r;
    wake_nxt    = 1'b0;
    ram_we      = 1'b0;
    if (accept) begin
      unique case (in_item.action)
        tlws_pkg::ACT_LOCK: begin
          ticket_nxt = next_r;
          priority if (gap == '0) begin
            status_nxt = tlws_pkg::ST_GRANTED;
            next_nxt   = next_r + tlws_pkg::TICKET_BITS'(1);
          end else if (32'(gap) >= tlws_pkg::SLOTS || occ_r[lk_slot]) begin
            status_nxt = tlws_pkg::ST_FULL;
          end else begin
            status_nxt       = tlws_pkg::ST_QUEUED;
            next_nxt         = next_r + tlws_pkg::TICKET_BITS'(1);
            occ_nxt[lk_slot] = 1'b1;
            ram_we           = 1'b1;
          end
        end
        tlws_pkg::ACT_UNLOCK: begin
          priority if (gap == '0) begin
            status_nxt = tlws_pkg::ST_UNLOCK_ERR;
            ticket_nxt = on_call_r;
          end else if (occ_r[ul_slot]) begin
            status_nxt       = tlws_pkg::ST_WOKE;
            ticket_nxt       = on_call_inc;
            on_call_nxt      = on_call_inc;
            occ_nxt[ul_slot] = 1'b0;
            wake_nxt         = 1'b1;
          end else begin
            status_nxt  = tlws_pkg::ST_NOWAIT;
            ticket_nxt  = on_call_inc;
            on_call_nxt = on_call_inc;
          end
        end
        default: begin
          status_nxt = tlws_pkg::ST_UNLOCK_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r    <= '0;
      on_call_r <= '0;
      occ_r     <= '0;
      valid_r   <= 1'b0;
      wake_r    <= 1'b0;
    end else begin
      next_r    <= next_nxt;
      on_call_r <= on_call_nxt;
      occ_r     <= occ_nxt;
      valid_r   <= valid_nxt;
      wake_r    <= wake_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    ticket_r <= ticket_nxt;
  end

  tlws_slot_ram #(
    .DEPTH (tlws_pkg::SLOTS),
    .WIDTH (tlws_pkg::TID_BITS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lk_slot),
    .wdata (in_item.thread_id),
    .raddr (ul_slot),
    .rdata (ram_rdata)
  );

  assign out_valid            = valid_r;
  assign out_item.status      = status_r;
  assign out_item.ticket      = ticket_r;
  assign out_item.wake_valid  = wake_r;
  assign out_item.wake_thread = wake_r ? ram_rdata : '0;

  a_accept_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item gave no result");

  a_busy_blocks_accept : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  a_wake_only_on_woke : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.wake_valid) |-> (out_item.status == tlws_pkg::ST_WOKE))
    else $error("wake raised without woke status");

  a_window_bound : assert property (@(posedge clk) disable iff (!rst_n)
    32'(gap) <= tlws_pkg::SLOTS)
    else $error("tickets outstanding exceed slot window");

endmodule
